[rtl/core/zkh_pkg.sv]
// Package: command, status and register codes plus field widths for the Zobrist key hasher.
package zkh_pkg;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned SYM_W    = 8;
  localparam int unsigned ROW_W    = 6;
  localparam int unsigned COL_W    = 4;
  localparam int unsigned HASH_W   = 64;
  localparam int unsigned WIDX_W   = 10;
  localparam int unsigned STATUS_W = 2;

  localparam int unsigned NW_W     = 11;
  localparam int unsigned NSYM_W   = 5;
  localparam int unsigned KLIM_W   = 7;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;

  localparam logic [CMD_W-1:0] CMD_LOAD_TABLE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_SYM   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_HASH_CHAR  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_SYMBOL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_WORKERS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMS_IN_USE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LIMIT   = 2'd2;

  localparam logic [NW_W-1:0]   NW_RESET   = 11'd1;
  localparam logic [NW_W-1:0]   NW_MAX     = 11'd1024;
  localparam logic [NSYM_W-1:0] NSYM_RESET = 5'd16;
  localparam logic [KLIM_W-1:0] KLIM_RESET = 7'd64;

endpackage

[rtl/core/zkh_intf.sv]
// Interfaces: input command channel and result channel of the Zobrist key hasher.
interface zkh_in_if;
  logic                           valid;
  logic                           ready;
  logic [zkh_pkg::CMD_W-1:0]      cmd;
  logic [zkh_pkg::SYM_W-1:0]      symbol_in;
  logic [zkh_pkg::ROW_W-1:0]      row_index;
  logic [zkh_pkg::COL_W-1:0]      col_index;
  logic [zkh_pkg::HASH_W-1:0]     table_word;
  logic                           last_char;

  modport source (output valid, cmd, symbol_in, row_index, col_index, table_word, last_char,
                  input ready);
  modport sink   (input valid, cmd, symbol_in, row_index, col_index, table_word, last_char,
                  output ready);
endinterface

interface zkh_out_if;
  logic                           valid;
  logic                           ready;
  logic [zkh_pkg::HASH_W-1:0]     hash_value;
  logic [zkh_pkg::WIDX_W-1:0]     worker_index;
  logic [zkh_pkg::STATUS_W-1:0]   status;

  modport source (output valid, hash_value, worker_index, status, input ready);
  modport sink   (input valid, hash_value, worker_index, status, output ready);
endinterface

[rtl/core/zkh_table_mem.sv]
// Random table memory: one write port, one read port, registered read data.
module zkh_table_mem #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned ADDR_W = 10
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [ADDR_W-1:0]             waddr_i,
  input  logic [zkh_pkg::HASH_W-1:0]    wdata_i,
  input  logic                          re_i,
  input  logic [ADDR_W-1:0]             raddr_i,
  output logic [zkh_pkg::HASH_W-1:0]    rdata_o
);

  logic [zkh_pkg::HASH_W-1:0] mem_q [DEPTH];
  logic [zkh_pkg::HASH_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/zkh_alpha_match.sv]
// Alphabet store and first-match symbol lookup.
module zkh_alpha_match #(
  parameter int unsigned MAX_SYMBOLS = 16,
  parameter int unsigned SLOT_W      = 4
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [zkh_pkg::COL_W-1:0]     wslot_i,
  input  logic [zkh_pkg::SYM_W-1:0]     wdata_i,
  input  logic [zkh_pkg::NSYM_W-1:0]    nsym_i,
  input  logic [zkh_pkg::SYM_W-1:0]     symbol_i,
  output logic                          hit_o,
  output logic [SLOT_W-1:0]             slot_o
);

  logic [zkh_pkg::SYM_W-1:0] alpha_q [MAX_SYMBOLS];

  always_ff @(posedge clk_i) begin
    if (we_i && (32'(wslot_i) < MAX_SYMBOLS)) begin
      alpha_q[SLOT_W'(wslot_i)] <= wdata_i;
    end
  end

  // Scan from the top so the lowest matching slot wins.
  always_comb begin
    hit_o  = 1'b0;
    slot_o = '0;
    for (int k = MAX_SYMBOLS - 1; k >= 0; k--) begin
      if ((32'(k) < 32'(nsym_i)) && (alpha_q[k] == symbol_i)) begin
        hit_o  = 1'b1;
        slot_o = SLOT_W'(k);
      end
    end
  end

endmodule

[rtl/core/zkh_mod_unit.sv]
// Bit-serial restoring remainder unit: dividend mod divisor, one bit per cycle.
module zkh_mod_unit #(
  parameter int unsigned DIV_W = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [DIV_W-1:0]              dividend_i,
  input  logic [zkh_pkg::NW_W-1:0]      divisor_i,
  output logic                          done_o,
  output logic [zkh_pkg::WIDX_W-1:0]    rem_o
);

  localparam int unsigned CNT_W = (DIV_W > 1) ? $clog2(DIV_W) : 1;

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic [DIV_W-1:0]            dvd_q, dvd_d;
  logic [zkh_pkg::NW_W-1:0]    dvs_q, dvs_d;
  logic [zkh_pkg::NW_W-1:0]    rem_q, rem_d;
  logic [zkh_pkg::NW_W:0]      trial;
  logic [zkh_pkg::NW_W:0]      diff;

  assign trial = {rem_q, dvd_q[DIV_W-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = (trial >= {1'b0, dvs_q}) ? diff[zkh_pkg::NW_W-1:0] : trial[zkh_pkg::NW_W-1:0];
      dvd_d = dvd_q << 1;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[zkh_pkg::WIDX_W-1:0];

endmodule

[rtl/core/zobrist_key_hash_and_dispatch_top.sv]
// Top level: Zobrist key hasher with worker dispatch.
//
// in_ch carries one transaction per command: a table word load, an alphabet
// symbol load, or one key character to hash. out_ch carries one transaction
// per key, on the character marked last: the 64-bit hash, the worker index
// (upper hash bits mod the worker count) and a status code. cfg_* writes the
// worker count, the number of alphabet symbols in use and the key length limit.
// A key character takes two steps: the table word is read from the random
// table memory (one read port, registered read data) and then XORed into the
// running hash. The last character then runs the bit-serial remainder unit on
// the upper hash bits before the result is loaded into the output register.
// Reset clears the running hash, position and status and sets the config
// registers to their defaults; the random table and alphabet hold garbage
// until loaded. A finished result sits in the output register while new
// commands are taken; if the receiver stalls and a second key completes,
// the block holds that result and stops taking input.
module zobrist_key_hash_and_dispatch_top #(
  parameter int unsigned MAX_KEY_LEN = 64,
  parameter int unsigned MAX_SYMBOLS = 16,
  parameter int unsigned SHIFT_BITS  = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  zkh_in_if.sink                           in_ch,
  zkh_out_if.source                        out_ch,
  input  logic                             cfg_we_i,
  input  logic [zkh_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [zkh_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned DEPTH  = MAX_KEY_LEN * MAX_SYMBOLS;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SLOT_W = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int unsigned POS_W  = $clog2(MAX_KEY_LEN + 1);
  localparam int unsigned DIV_W  = zkh_pkg::HASH_W - SHIFT_BITS;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_XOR  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;

  logic [1:0]                       state_q, state_d;
  logic [zkh_pkg::HASH_W-1:0]       hash_q, hash_d;
  logic [POS_W-1:0]                 pos_q, pos_d;
  logic [zkh_pkg::STATUS_W-1:0]     sticky_q, sticky_d;
  logic                             pend_ok_q, pend_ok_d;
  logic                             pend_last_q, pend_last_d;
  logic [zkh_pkg::HASH_W-1:0]       res_hash_q, res_hash_d;
  logic [zkh_pkg::STATUS_W-1:0]     res_status_q, res_status_d;
  logic                             out_valid_q, out_valid_d;
  logic [zkh_pkg::HASH_W-1:0]       out_hash_q, out_hash_d;
  logic [zkh_pkg::WIDX_W-1:0]       out_widx_q, out_widx_d;
  logic [zkh_pkg::STATUS_W-1:0]     out_status_q, out_status_d;
  logic [zkh_pkg::NW_W-1:0]         nw_q;
  logic [zkh_pkg::NSYM_W-1:0]       nsym_q;
  logic [zkh_pkg::KLIM_W-1:0]       klim_q;

  logic                             in_fire;
  logic                             tbl_we;
  logic [ADDR_W-1:0]                tbl_waddr;
  logic                             tbl_re;
  logic [ADDR_W-1:0]                tbl_raddr;
  logic [zkh_pkg::HASH_W-1:0]       tbl_rdata;
  logic                             sym_we;
  logic                             sym_hit;
  logic [SLOT_W-1:0]                sym_slot;
  logic [31:0]                      lim_eff;
  logic [zkh_pkg::NW_W-1:0]         nw_eff;
  logic [zkh_pkg::HASH_W-1:0]       hash_fin;
  logic                             div_start;
  logic                             div_done;
  logic [zkh_pkg::WIDX_W-1:0]       div_rem;

  assign in_ch.ready = (state_q == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign tbl_we    = in_fire && (in_ch.cmd == zkh_pkg::CMD_LOAD_TABLE)
                     && (32'(in_ch.row_index) < MAX_KEY_LEN)
                     && (32'(in_ch.col_index) < MAX_SYMBOLS);
  assign tbl_waddr = ADDR_W'(32'(in_ch.row_index) * MAX_SYMBOLS + 32'(in_ch.col_index));
  assign tbl_raddr = ADDR_W'(32'(pos_q) * MAX_SYMBOLS + 32'(sym_slot));
  assign sym_we    = in_fire && (in_ch.cmd == zkh_pkg::CMD_LOAD_SYM);

  assign lim_eff = (32'(klim_q) > MAX_KEY_LEN) ? MAX_KEY_LEN : 32'(klim_q);
  assign nw_eff  = (nw_q == '0) ? zkh_pkg::NW_RESET
                 : ((nw_q > zkh_pkg::NW_MAX) ? zkh_pkg::NW_MAX : nw_q);

  assign hash_fin  = hash_q ^ (pend_ok_q ? tbl_rdata : '0);
  assign div_start = (state_q == S_XOR) && pend_last_q;

  zkh_table_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (in_ch.table_word),
    .re_i    (tbl_re),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  zkh_alpha_match #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .SLOT_W      (SLOT_W)
  ) u_alpha (
    .clk_i    (clk_i),
    .we_i     (sym_we),
    .wslot_i  (in_ch.col_index),
    .wdata_i  (in_ch.symbol_in),
    .nsym_i   (nsym_q),
    .symbol_i (in_ch.symbol_in),
    .hit_o    (sym_hit),
    .slot_o   (sym_slot)
  );

  zkh_mod_unit #(
    .DIV_W (DIV_W)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (DIV_W'(hash_fin >> SHIFT_BITS)),
    .divisor_i  (nw_eff),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  always_comb begin
    state_d      = state_q;
    hash_d       = hash_q;
    pos_d        = pos_q;
    sticky_d     = sticky_q;
    pend_ok_d    = pend_ok_q;
    pend_last_d  = pend_last_q;
    res_hash_d   = res_hash_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q;
    out_hash_d   = out_hash_q;
    out_widx_d   = out_widx_q;
    out_status_d = out_status_q;
    tbl_re       = 1'b0;

    if (out_valid_q && out_ch.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire && (in_ch.cmd == zkh_pkg::CMD_HASH_CHAR)) begin
          pend_ok_d   = 1'b0;
          pend_last_d = in_ch.last_char;
          state_d     = S_XOR;
          if (pos_q < POS_W'(MAX_KEY_LEN)) begin
            pos_d = pos_q + 1'b1;
          end
          if (sticky_q == zkh_pkg::ST_OK) begin
            if (32'(pos_q) >= lim_eff) begin
              sticky_d = zkh_pkg::ST_TOO_LONG;
            end else if (!sym_hit) begin
              sticky_d = zkh_pkg::ST_BAD_SYMBOL;
            end else begin
              tbl_re    = 1'b1;
              pend_ok_d = 1'b1;
            end
          end
        end
      end
      S_XOR: begin
        if (pend_last_q) begin
          res_hash_d   = hash_fin;
          res_status_d = sticky_q;
          hash_d       = '0;
          pos_d        = '0;
          sticky_d     = zkh_pkg::ST_OK;
          state_d      = S_DIV;
        end else begin
          hash_d  = hash_fin;
          state_d = S_IDLE;
        end
      end
      S_DIV: begin
        if (div_done && (!out_valid_q || out_ch.ready)) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_hash_d   = (res_status_q == zkh_pkg::ST_OK) ? res_hash_q : '0;
          out_widx_d   = (res_status_q == zkh_pkg::ST_OK) ? div_rem : '0;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      hash_q      <= '0;
      pos_q       <= '0;
      sticky_q    <= zkh_pkg::ST_OK;
      pend_ok_q   <= 1'b0;
      pend_last_q <= 1'b0;
      out_valid_q <= 1'b0;
      nw_q        <= zkh_pkg::NW_RESET;
      nsym_q      <= zkh_pkg::NSYM_RESET;
      klim_q      <= zkh_pkg::KLIM_RESET;
    end else begin
      state_q     <= state_d;
      hash_q      <= hash_d;
      pos_q       <= pos_d;
      sticky_q    <= sticky_d;
      pend_ok_q   <= pend_ok_d;
      pend_last_q <= pend_last_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          zkh_pkg::CFG_NUM_WORKERS: nw_q   <= cfg_data_i;
          zkh_pkg::CFG_SYMS_IN_USE: nsym_q <= cfg_data_i[zkh_pkg::NSYM_W-1:0];
          zkh_pkg::CFG_KEY_LIMIT:   klim_q <= cfg_data_i[zkh_pkg::KLIM_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_hash_q   <= res_hash_d;
    res_status_q <= res_status_d;
    out_hash_q   <= out_hash_d;
    out_widx_q   <= out_widx_d;
    out_status_q <= out_status_d;
  end

  assign out_ch.valid        = out_valid_q;
  assign out_ch.hash_value   = out_hash_q;
  assign out_ch.worker_index = out_widx_q;
  assign out_ch.status       = out_status_q;

`ifndef ASSERT_OFF
  a_xor_follows_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_XOR) |->
      $past(in_ch.valid && in_ch.ready && (in_ch.cmd == zkh_pkg::CMD_HASH_CHAR)))
    else $error("hash step without an accepted key character");

  a_pos_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pos_q) <= MAX_KEY_LEN)
    else $error("key position beyond table rows");

  a_read_only_when_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_ok_q && (state_q == S_XOR) |-> (sticky_q == zkh_pkg::ST_OK))
    else $error("table word XORed after an error");

  a_err_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_status_q != zkh_pkg::ST_OK) |->
      (out_hash_q == '0) && (out_widx_q == '0))
    else $error("error result carries a hash");

  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ch.ready |=> out_valid_q && $stable(out_hash_q))
    else $error("pending result overwritten");
`endif

endmodule

[verif/zobrist_key_hash_and_dispatch_top_tb.sv]
// Testbench: Zobrist key hasher, random and directed key traffic checked against a predictor.
`timescale 1ns / 100ps

module zobrist_key_hash_and_dispatch_top_tb;

  localparam int unsigned KEY_LEN     = 64;
  localparam int unsigned SYMS        = 16;
  localparam int unsigned SHIFT       = 32;
  localparam int          LONG_HOLD   = 400;
  localparam int          IDLE_WAIT   = 80;
  localparam int          CYCLE_LIMIT = 1_000_000;
  localparam int          MAX_REPORTS = 10;

  localparam logic [zkh_pkg::CMD_W-1:0]     CMD_UNUSED = 2'd3;
  localparam logic [zkh_pkg::CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;

  typedef struct packed {
    logic [zkh_pkg::CMD_W-1:0]  cmd;
    logic [zkh_pkg::SYM_W-1:0]  sym;
    logic [zkh_pkg::ROW_W-1:0]  row;
    logic [zkh_pkg::COL_W-1:0]  col;
    logic [zkh_pkg::HASH_W-1:0] word;
    logic                       last;
  } zkh_cmd_t;

  typedef struct packed {
    logic [zkh_pkg::HASH_W-1:0]   hash;
    logic [zkh_pkg::WIDX_W-1:0]   widx;
    logic [zkh_pkg::STATUS_W-1:0] status;
  } digest_t;

  class zobrist_hash_keeper;
    logic [zkh_pkg::HASH_W-1:0]   rand_tbl [KEY_LEN*SYMS];
    logic [zkh_pkg::SYM_W-1:0]    alpha [SYMS];
    logic [zkh_pkg::HASH_W-1:0]   run_hash;
    int unsigned                  char_pos;
    logic [zkh_pkg::STATUS_W-1:0] sticky;
    logic [zkh_pkg::NW_W-1:0]     nw;
    logic [zkh_pkg::NSYM_W-1:0]   nsym;
    logic [zkh_pkg::KLIM_W-1:0]   klim;
    digest_t                      digest_q [$];
    int                           faults;

    function new();
      nw       = zkh_pkg::NW_RESET;
      nsym     = zkh_pkg::NSYM_RESET;
      klim     = zkh_pkg::KLIM_RESET;
      run_hash = '0;
      char_pos = 0;
      sticky   = zkh_pkg::ST_OK;
      faults   = 0;
    endfunction

    function void apply_reg(logic [zkh_pkg::CFG_IDX_W-1:0] idx,
                            logic [zkh_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        zkh_pkg::CFG_NUM_WORKERS: nw = data[zkh_pkg::NW_W-1:0];
        zkh_pkg::CFG_SYMS_IN_USE: nsym = data[zkh_pkg::NSYM_W-1:0];
        zkh_pkg::CFG_KEY_LIMIT:   klim = data[zkh_pkg::KLIM_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_command(zkh_cmd_t c);
      int unsigned lim;
      int unsigned nsyms;
      int unsigned workers;
      int unsigned pos;
      int unsigned slot;
      bit          found;
      digest_t     d;
      logic [zkh_pkg::HASH_W-1:0] upper;
      logic [zkh_pkg::HASH_W-1:0] rem;
      case (c.cmd)
        zkh_pkg::CMD_LOAD_TABLE: rand_tbl[{c.row, c.col}] = c.word;
        zkh_pkg::CMD_LOAD_SYM:   alpha[c.col] = c.sym;
        zkh_pkg::CMD_HASH_CHAR: begin
          lim   = (klim > KEY_LEN) ? KEY_LEN : klim;
          nsyms = (nsym > SYMS) ? SYMS : nsym;
          pos   = char_pos;
          if (char_pos < KEY_LEN) char_pos++;
          if (sticky == zkh_pkg::ST_OK) begin
            if (pos >= lim) begin
              sticky = zkh_pkg::ST_TOO_LONG;
            end else begin
              found = 1'b0;
              slot  = 0;
              for (int k = 0; k < nsyms; k++) begin
                if (!found && alpha[k] == c.sym) begin
                  found = 1'b1;
                  slot  = k;
                end
              end
              if (!found) sticky = zkh_pkg::ST_BAD_SYMBOL;
              else run_hash ^= rand_tbl[pos*SYMS + slot];
            end
          end
          if (c.last) begin
            d.status = sticky;
            d.hash   = '0;
            d.widx   = '0;
            if (sticky == zkh_pkg::ST_OK) begin
              workers = (nw > zkh_pkg::NW_MAX) ? zkh_pkg::NW_MAX : nw;
              if (workers == 0) workers = 1;
              upper  = run_hash >> SHIFT;
              rem    = upper % workers;
              d.hash = run_hash;
              d.widx = rem[zkh_pkg::WIDX_W-1:0];
            end
            digest_q.push_back(d);
            run_hash = '0;
            char_pos = 0;
            sticky   = zkh_pkg::ST_OK;
          end
        end
        default: ;
      endcase
    endfunction

    function void match_digest(logic [zkh_pkg::HASH_W-1:0] h, logic [zkh_pkg::WIDX_W-1:0] w,
                               logic [zkh_pkg::STATUS_W-1:0] s);
      digest_t d;
      if (digest_q.size() == 0) begin
        faults++;
        if (faults <= MAX_REPORTS)
          $display("%0t: unexpected transaction hash %h worker %0d status %0d", $time, h, w, s);
        return;
      end
      d = digest_q.pop_front();
      if (d.hash !== h || d.widx !== w || d.status !== s) begin
        faults++;
        if (faults <= MAX_REPORTS)
          $display("%0t: mismatch exp hash %h worker %0d status %0d, got %h %0d %0d",
                   $time, d.hash, d.widx, d.status, h, w, s);
      end
    endfunction
  endclass

  bit                              clk_i;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [zkh_pkg::CFG_IDX_W-1:0]   cfg_index_i;
  logic [zkh_pkg::CFG_DATA_W-1:0]  cfg_data_i;

  zkh_in_if  in_ch ();
  zkh_out_if out_ch ();

  zobrist_key_hash_and_dispatch_top #(
    .MAX_KEY_LEN (KEY_LEN),
    .MAX_SYMBOLS (SYMS),
    .SHIFT_BITS  (SHIFT)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  zobrist_hash_keeper book;

  int          cycles      = 0;
  int          sent_count  = 0;
  int          burst_left  = 0;
  int unsigned gap_max     = 0;
  int          hold_asked  = 0;
  int          hold_served = 0;
  int          hold_left   = 0;
  logic [15:0] pat         = 16'hFFFF;
  int          pat_age     = 0;
  int          pat_bit     = 0;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_ch.valid && in_ch.ready)
      book.take_command({in_ch.cmd, in_ch.symbol_in, in_ch.row_index, in_ch.col_index,
                         in_ch.table_word, in_ch.last_char});
    if (rst_ni && out_ch.valid && out_ch.ready)
      book.match_digest(out_ch.hash_value, out_ch.worker_index, out_ch.status);
  end

  // receiver: rotating stall pattern, plus long hold-offs on request
  always @(negedge clk_i) begin
    if (hold_left == 0 && hold_served != hold_asked) begin
      hold_served++;
      hold_left = LONG_HOLD;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      if (pat_age == 0) begin
        pat     = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
        pat_age = 48;
      end
      pat_age--;
      out_ch.ready <= pat[pat_bit];
      pat_bit = (pat_bit + 1) % 16;
    end
  end

  function automatic zkh_cmd_t noise();
    zkh_cmd_t c;
    c.cmd  = CMD_UNUSED;
    c.sym  = 8'($urandom);
    c.row  = 6'($urandom);
    c.col  = 4'($urandom);
    c.word = {$urandom, $urandom};
    c.last = 1'($urandom);
    return c;
  endfunction

  function automatic zkh_cmd_t load_word(logic [zkh_pkg::ROW_W-1:0] row,
                                         logic [zkh_pkg::COL_W-1:0] col,
                                         logic [zkh_pkg::HASH_W-1:0] word);
    zkh_cmd_t c;
    c      = noise();
    c.cmd  = zkh_pkg::CMD_LOAD_TABLE;
    c.row  = row;
    c.col  = col;
    c.word = word;
    return c;
  endfunction

  function automatic zkh_cmd_t load_sym(logic [zkh_pkg::COL_W-1:0] col,
                                        logic [zkh_pkg::SYM_W-1:0] sym);
    zkh_cmd_t c;
    c     = noise();
    c.cmd = zkh_pkg::CMD_LOAD_SYM;
    c.col = col;
    c.sym = sym;
    return c;
  endfunction

  function automatic zkh_cmd_t key_char(logic [zkh_pkg::SYM_W-1:0] sym, bit last);
    zkh_cmd_t c;
    c      = noise();
    c.cmd  = zkh_pkg::CMD_HASH_CHAR;
    c.sym  = sym;
    c.last = last;
    return c;
  endfunction

  function automatic logic [zkh_pkg::SYM_W-1:0] stray_symbol();
    logic [zkh_pkg::SYM_W-1:0] v;
    bit                        clash;
    do begin
      v     = 8'($urandom);
      clash = 1'b0;
      for (int k = 0; k < SYMS; k++)
        if (book.alpha[k] == v) clash = 1'b1;
    end while (clash);
    return v;
  endfunction

  function automatic logic [zkh_pkg::SYM_W-1:0] pick_char();
    int unsigned eff;
    eff = (book.nsym > SYMS) ? SYMS : book.nsym;
    if (eff == 0 || $urandom_range(0, 9) == 0) return 8'($urandom);
    return book.alpha[$urandom_range(0, eff - 1)];
  endfunction

  task automatic offer(input zkh_cmd_t c);
    int unsigned gap;
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= c.cmd;
    in_ch.symbol_in  <= c.sym;
    in_ch.row_index  <= c.row;
    in_ch.col_index  <= c.col;
    in_ch.table_word <= c.word;
    in_ch.last_char  <= c.last;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    if (c.cmd != CMD_UNUSED) sent_count++;
    @(negedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(0, gap_max);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (book.digest_q.size() != 0) @(negedge clk_i);
    repeat (IDLE_WAIT) @(negedge clk_i);
  endtask

  task automatic poke_reg(input logic [zkh_pkg::CFG_IDX_W-1:0] idx,
                          input logic [zkh_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    book.apply_reg(idx, data);
    @(negedge clk_i);
  endtask

  task automatic set_regs(input logic [zkh_pkg::NW_W-1:0] nw,
                          input logic [zkh_pkg::NSYM_W-1:0] nsym,
                          input logic [zkh_pkg::KLIM_W-1:0] klim);
    settle();
    poke_reg(CFG_SPARE, 11'($urandom));
    poke_reg(zkh_pkg::CFG_NUM_WORKERS, nw);
    poke_reg(zkh_pkg::CFG_SYMS_IN_USE, {6'($urandom), nsym});
    poke_reg(zkh_pkg::CFG_KEY_LIMIT, {4'($urandom), klim});
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_stores();
    bit                         taken [256];
    logic [zkh_pkg::SYM_W-1:0]  v;
    logic [zkh_pkg::HASH_W-1:0] w;
    gap_max = 2;
    taken[0]   = 1'b1;
    taken[255] = 1'b1;
    offer(load_sym(4'd0, 8'h00));
    for (int c = 1; c < SYMS - 1; c++) begin
      do v = 8'($urandom_range(1, 254)); while (taken[v]);
      taken[v] = 1'b1;
      offer(load_sym(4'(c), v));
    end
    offer(load_sym(4'd15, 8'hFF));
    for (int r = 0; r < KEY_LEN; r++) begin
      for (int c = 0; c < SYMS; c++) begin
        w = {$urandom, $urandom};
        if (r == 0 && c == 0) w = 64'hFFFF_FFFF_0000_0000;
        if (c == 15 && (r == 0 || r == 63)) w = '1;
        if (r == 1 && c == 0) w = '0;
        offer(load_word(6'(r), 4'(c), w));
      end
    end
  endtask

  task automatic directed_keys();
    logic [zkh_pkg::SYM_W-1:0] odd;
    gap_max = 3;
    offer(key_char(book.alpha[0], 1'b1));
    offer(key_char(book.alpha[15], 1'b1));
    // loads and an unused command in the middle of a key
    offer(key_char(book.alpha[3], 1'b0));
    offer(load_word(6'd1, 4'd4, '1));
    offer(key_char(book.alpha[4], 1'b0));
    offer(noise());
    offer(load_sym(4'd6, 8'hA5));
    offer(key_char(8'hA5, 1'b1));
    odd = stray_symbol();
    offer(key_char(odd, 1'b0));
    offer(key_char(book.alpha[1], 1'b1));
    // duplicate symbol, first slot wins
    offer(load_sym(4'd9, book.alpha[2]));
    offer(key_char(book.alpha[2], 1'b1));
    set_regs(zkh_pkg::NW_MAX, 5'd16, 7'd2);
    offer(key_char(book.alpha[5], 1'b0));
    offer(key_char(book.alpha[6], 1'b0));
    offer(key_char(book.alpha[7], 1'b1));
    odd = stray_symbol();
    offer(key_char(odd, 1'b0));
    offer(key_char(book.alpha[8], 1'b0));
    offer(key_char(book.alpha[9], 1'b1));
    offer(key_char(book.alpha[10], 1'b0));
    offer(key_char(book.alpha[11], 1'b1));
  endtask

  task automatic random_traffic(input int n, input int unsigned gm);
    int pick;
    int len;
    gap_max    = gm;
    sent_count = 0;
    while (sent_count < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 78) begin
        pick = $urandom_range(0, 99);
        if (pick < 88) len = $urandom_range(1, 6);
        else if (pick < 97) len = $urandom_range(7, 20);
        else len = $urandom_range(60, 70);
        for (int k = 0; k < len; k++) begin
          pick = $urandom_range(0, 99);
          if (pick < 4) offer(load_word(6'($urandom), 4'($urandom), {$urandom, $urandom}));
          else if (pick < 6) offer(noise());
          offer(key_char(pick_char(), (k == len - 1) && ($urandom_range(0, 29) != 0)));
        end
      end else if (pick < 88) begin
        offer(load_word(6'($urandom), 4'($urandom), {$urandom, $urandom}));
      end else if (pick < 94) begin
        offer(load_sym(4'($urandom), ($urandom_range(0, 1) == 0) ? pick_char() : 8'($urandom)));
      end else begin
        offer(noise());
      end
    end
  endtask

  initial begin
    book             = new();
    rst_ni           = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.cmd        = CMD_UNUSED;
    in_ch.symbol_in  = '0;
    in_ch.row_index  = '0;
    in_ch.col_index  = '0;
    in_ch.table_word = '0;
    in_ch.last_char  = 1'b0;
    out_ch.ready     = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_index_i      = zkh_pkg::CFG_NUM_WORKERS;
    cfg_data_i       = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    set_regs(11'd7, 5'd16, 7'd64);
    load_stores();
    directed_keys();

    set_regs(zkh_pkg::NW_MAX, 5'd16, 7'd64);
    hold_asked++;
    random_traffic(120, 6);
    set_regs(11'd0, 5'd0, 7'd64);
    random_traffic(60, 4);
    set_regs(11'd2047, 5'd31, 7'd0);
    random_traffic(60, 4);
    set_regs(11'd1, 5'd1, 7'd1);
    random_traffic(80, 8);
    set_regs(11'd1025, 5'd17, 7'd127);
    random_traffic(100, 3);
    set_regs(11'($urandom_range(1, 1024)), 5'($urandom_range(1, 16)),
             7'($urandom_range(1, 64)));
    hold_asked++;
    random_traffic(120, 5);
    set_regs(11'($urandom), 5'($urandom), 7'($urandom));
    random_traffic(100, 5);
    set_regs(11'd3, 5'd16, 7'd64);
    random_traffic(50, 0);

    settle();
    if (book.faults == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
